/* design/rk4s_pkg.sv */
// Shared types and constants for the staged RK4 rigid-body integrator.
// No dependencies; imported by every module of the block.
package rk4s_pkg;

    localparam int VAL_W   = 32;
    localparam int DT_W    = 21;
    localparam int IDX_W   = 6;
    localparam int NUM_VAL = 6;
    localparam int NUM_CON = 3;
    localparam int P_W     = DT_W + VAL_W;   // dt * |x| * weight
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [DT_W-1:0] DT_RESET = 21'd1092;

    localparam logic [2:0] OP_LOAD_BODY = 3'd0;
    localparam logic [2:0] OP_LOAD_CON  = 3'd1;
    localparam logic [2:0] OP_EVAL_BODY = 3'd2;
    localparam logic [2:0] OP_EVAL_CON  = 3'd3;
    localparam logic [2:0] OP_ADVANCE   = 3'd4;
    localparam logic [2:0] OP_START     = 3'd5;
    localparam logic [2:0] OP_END       = 3'd6;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ONE   = 3'd1;
    localparam logic [2:0] ST_TWO   = 3'd2;
    localparam logic [2:0] ST_THREE = 3'd3;
    localparam logic [2:0] ST_FOUR  = 3'd4;

    localparam logic [1:0] SUB_NONE = 2'd0;
    localparam logic [1:0] SUB_HALF = 2'd1;
    localparam logic [1:0] SUB_FULL = 2'd2;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef t_val [NUM_VAL-1:0] t_vec;
    typedef t_val [NUM_CON-1:0] t_cvec;

    typedef enum logic [2:0] {
        K_NONE,
        K_LOAD_B,
        K_LOAD_C,
        K_EVAL_STEP,
        K_EVAL_FIN,
        K_EVAL_C
    } t_kind;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] index;
        t_val             value_a;
        t_val             value_b;
        t_val             value_c;
        t_val             value_d;
        t_val             value_e;
        t_val             value_f;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        t_val             out_angle;
        t_val             out_angular_velocity;
        t_val             out_position_x;
        t_val             out_position_y;
        t_val             out_velocity_x;
        t_val             out_velocity_y;
        logic [2:0]       stage_now;
        logic [1:0]       sub_step_code;
        logic             final_flag;
        logic             saturated;
    } t_out;

    // Decoded request passed from the front end to the execution pipeline.
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        t_vec             v;
        logic             dbl;        // stage weight 2
        logic             full_step;  // next-stage offset is a full dt
        logic [2:0]       stage;
        logic [1:0]       sub;
        logic             fin;
    } t_cmd;

endpackage

/* design/rk4s_front.sv */
// Front end: owns the stage register and classifies each accepted request.
// Depends on rk4s_pkg.
module rk4s_front
    import rk4s_pkg::*;
#(
    parameter int MAX_BODIES      = 64,
    parameter int MAX_CONSTRAINTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  logic i_take,
    output t_cmd o_cmd
);

    logic [2:0] r_stage;
    logic [2:0] n_stage;
    logic       active;
    logic       body_ok;
    logic       con_ok;

    always_comb begin
        active  = (r_stage >= ST_ONE) && (r_stage <= ST_FOUR);
        body_ok = (32'(i_item.index) < 32'(MAX_BODIES));
        con_ok  = (32'(i_item.index) < 32'(MAX_CONSTRAINTS));
        n_stage = r_stage;

        o_cmd           = '0;
        o_cmd.kind      = K_NONE;
        o_cmd.idx       = i_item.index;
        o_cmd.v[0]      = i_item.value_a;
        o_cmd.v[1]      = i_item.value_b;
        o_cmd.v[2]      = i_item.value_c;
        o_cmd.v[3]      = i_item.value_d;
        o_cmd.v[4]      = i_item.value_e;
        o_cmd.v[5]      = i_item.value_f;
        o_cmd.dbl       = (r_stage == ST_TWO) || (r_stage == ST_THREE);
        o_cmd.full_step = (r_stage == ST_THREE);

        case (i_item.op)
            OP_LOAD_BODY: begin
                if (body_ok) o_cmd.kind = K_LOAD_B;
            end
            OP_LOAD_CON: begin
                if (con_ok) o_cmd.kind = K_LOAD_C;
            end
            OP_EVAL_BODY: begin
                if (active && body_ok) begin
                    if (r_stage == ST_FOUR) begin
                        o_cmd.kind = K_EVAL_FIN;
                        o_cmd.fin  = 1'b1;
                    end else begin
                        o_cmd.kind = K_EVAL_STEP;
                        o_cmd.sub  = (r_stage == ST_THREE) ? SUB_FULL : SUB_HALF;
                    end
                end
            end
            OP_EVAL_CON: begin
                if (active && con_ok) begin
                    o_cmd.kind = K_EVAL_C;
                    o_cmd.fin  = (r_stage == ST_FOUR);
                end
            end
            OP_ADVANCE: n_stage = active ? r_stage + 3'd1 : ST_IDLE;
            OP_START:   n_stage = ST_ONE;
            OP_END:     n_stage = ST_IDLE;
            default:    n_stage = r_stage;
        endcase

        o_cmd.stage = n_stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
        end else if (i_take) begin
            r_stage <= n_stage;
        end
    end

endmodule

/* design/rk4s_queue.sv */
// Short request queue between front end and execution pipeline.
// Depends on rk4s_pkg.
module rk4s_queue
    import rk4s_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule

/* design/rk4s_back.sv */
// Execution pipeline: state memories, dt products, divide-by-six, saturating
// accumulate and next-stage state. Depends on rk4s_pkg.
module rk4s_back
    import rk4s_pkg::*;
#(
    parameter int MAX_BODIES      = 64,
    parameter int MAX_CONSTRAINTS = 64,
    parameter int FRAC_BITS       = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [DT_W-1:0] i_time_step,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    output t_out            o_out,
    input  logic            i_out_stall
);

    localparam int IDX_SPAN = 2 ** IDX_W;
    localparam int B_DEPTH  = (MAX_BODIES < IDX_SPAN) ? MAX_BODIES : IDX_SPAN;
    localparam int C_DEPTH  = (MAX_CONSTRAINTS < IDX_SPAN) ? MAX_CONSTRAINTS : IDX_SPAN;
    localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int C_AW     = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

    // floor(t/3) is split in two chunks, each by a reciprocal multiply
    localparam int TW   = P_W - FRAC_BITS;
    localparam int LO_W = (TW + 1) / 2;
    localparam int HI_W = TW - LO_W;
    localparam int K1   = (HI_W % 2 == 1) ? HI_W : HI_W + 1;
    localparam int K2   = ((LO_W + 2) % 2 == 1) ? LO_W + 2 : LO_W + 3;
    localparam logic [K1-1:0] M1 = K1'(((64'd1 << K1) + 64'd1) / 64'd3);
    localparam logic [K2-1:0] M2 = K2'(((64'd1 << K2) + 64'd1) / 64'd3);
    localparam logic [P_W-1:0] RND6     = P_W'(3) << FRAC_BITS;
    localparam logic [P_W-1:0] RND_HALF = P_W'(1) << FRAC_BITS;
    localparam logic [P_W-1:0] RND_FULL = P_W'(1) << (FRAC_BITS - 1);

    function automatic int body_src(input int j);
        case (j)
            0:       return 1;
            1:       return 0;
            2:       return 4;
            3:       return 5;
            4:       return 2;
            default: return 3;
        endcase
    endfunction

    function automatic int vel_src(input int k);
        case (k)
            0:       return 0;
            1:       return 2;
            default: return 3;
        endcase
    endfunction

    function automatic int vel_slot(input int k);
        case (k)
            0:       return 1;
            1:       return 4;
            default: return 5;
        endcase
    endfunction

    function automatic int pos_slot(input int k);
        case (k)
            0:       return 0;
            1:       return 2;
            default: return 3;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] magnitude(input t_val x);
        return x[VAL_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [TW-1:0] div_n(input logic [P_W-1:0] p, input logic full);
        logic [P_W-1:0] s;
        s = p + (full ? RND_FULL : RND_HALF);
        return full ? s[P_W-1:FRAC_BITS] : {1'b0, s[P_W-1:FRAC_BITS+1]};
    endfunction

    function automatic logic signed [63:0] add_term(input t_val base, input logic [TW-1:0] q,
                                                    input logic neg);
        logic signed [63:0] qx;
        logic signed [63:0] bx;
        qx = $signed({{(64-TW){1'b0}}, q});
        bx = $signed({{(64-VAL_W){base[VAL_W-1]}}, base});
        return bx + (neg ? -qx : qx);
    endfunction

    function automatic t_val clamp32(input logic signed [63:0] s);
        if (s > 64'sd2147483647) return t_val'(32'h7fff_ffff);
        if (s < -64'sd2147483648) return t_val'(32'h8000_0000);
        return t_val'(s[VAL_W-1:0]);
    endfunction

    function automatic logic ovf32(input logic signed [63:0] s);
        return !((&s[63:VAL_W-1]) || !(|s[63:VAL_W-1]));
    endfunction

    logic en;
    assign en    = !o_out_valid || !i_out_stall;
    assign o_pop = en && i_cmd_valid;

    // stage registers
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    t_cmd r_s1, r_s2, r_s3, r_s4;
    t_vec r_s1_ini, r_s2_ini, r_s3_ini, r_s4_ini;
    t_out r_out;

    logic [P_W-1:0]       r_s2_pa  [NUM_VAL];
    logic                 r_s2_na  [NUM_VAL];
    logic [P_W-1:0]       r_s2_pv  [NUM_CON];
    logic                 r_s2_nv  [NUM_CON];
    logic [HI_W-1:0]      r_s3_th  [NUM_VAL];
    logic [LO_W-1:0]      r_s3_tl  [NUM_VAL];
    logic [HI_W+K1-1:0]   r_s3_pr1 [NUM_VAL];
    logic                 r_s3_na  [NUM_VAL];
    t_cvec                r_s3_vel;
    logic                 r_s3_satv;
    logic [HI_W-1:0]      r_s4_qh  [NUM_VAL];
    logic [LO_W+2+K2-1:0] r_s4_pr2 [NUM_VAL];
    logic                 r_s4_na  [NUM_VAL];
    logic [P_W-1:0]       r_s4_pp  [NUM_CON];
    logic                 r_s4_np  [NUM_CON];
    t_cvec                r_s4_vel;
    logic                 r_s4_satv;

    // memories and read-after-write bypass
    t_vec  r_ini_mem   [B_DEPTH];
    t_vec  r_acc_b_mem [B_DEPTH];
    t_cvec r_acc_c_mem [C_DEPTH];
    t_vec  r_acc_b_rd;
    t_cvec r_acc_c_rd;
    logic  r_byp_b_valid, r_byp_c_valid;
    logic [IDX_W-1:0] r_byp_b_idx, r_byp_c_idx;
    t_vec  r_byp_b_data;
    t_cvec r_byp_c_data;

    // ---- stage 1: dt products ----
    logic [P_W-1:0] s1_pa [NUM_VAL];
    logic           s1_na [NUM_VAL];
    logic [P_W-1:0] s1_pv [NUM_CON];
    logic           s1_nv [NUM_CON];

    always_comb begin
        logic [P_W-1:0] m;
        t_val           x;
        for (int j = 0; j < NUM_VAL; j++) begin
            x        = (r_s1.kind == K_EVAL_C) ? r_s1.v[j % NUM_CON] : r_s1.v[body_src(j)];
            s1_na[j] = x[VAL_W-1];
            m        = i_time_step * magnitude(x);
            s1_pa[j] = r_s1.dbl ? (m << 1) : m;
        end
        for (int k = 0; k < NUM_CON; k++) begin
            x        = r_s1.v[vel_src(k)];
            s1_nv[k] = x[VAL_W-1];
            s1_pv[k] = i_time_step * magnitude(x);
        end
    end

    // ---- stage 2: rounding, high-chunk reciprocal, new velocities ----
    logic [HI_W-1:0]    s2_th  [NUM_VAL];
    logic [LO_W-1:0]    s2_tl  [NUM_VAL];
    logic [HI_W+K1-1:0] s2_pr1 [NUM_VAL];
    t_cvec              s2_vel;
    logic               s2_satv;

    always_comb begin
        logic [P_W-1:0]     s;
        logic signed [63:0] sum;
        s2_satv = 1'b0;
        for (int j = 0; j < NUM_VAL; j++) begin
            s         = r_s2_pa[j] + RND6;
            s2_th[j]  = s[P_W-1 -: HI_W];
            s2_tl[j]  = s[FRAC_BITS +: LO_W];
            s2_pr1[j] = s2_th[j] * M1;
        end
        for (int k = 0; k < NUM_CON; k++) begin
            sum       = add_term(r_s2_ini[vel_slot(k)], div_n(r_s2_pv[k], r_s2.full_step),
                                 r_s2_nv[k]);
            s2_vel[k] = clamp32(sum);
            s2_satv   = s2_satv | ovf32(sum);
        end
    end

    // ---- stage 3: remainder, low-chunk reciprocal, position products ----
    logic [HI_W-1:0]      s3_qh  [NUM_VAL];
    logic [LO_W+2+K2-1:0] s3_pr2 [NUM_VAL];
    logic [P_W-1:0]       s3_pp  [NUM_CON];
    logic                 s3_np  [NUM_CON];

    always_comb begin
        logic [HI_W+1:0] rem;
        logic [LO_W+1:0] u;
        for (int j = 0; j < NUM_VAL; j++) begin
            s3_qh[j]  = r_s3_pr1[j][K1 +: HI_W];
            rem       = {2'b00, r_s3_th[j]} - ({2'b00, s3_qh[j]} << 1) - {2'b00, s3_qh[j]};
            u         = {rem[1:0], r_s3_tl[j]};
            s3_pr2[j] = u * M2;
        end
        for (int k = 0; k < NUM_CON; k++) begin
            s3_np[k] = r_s3_vel[k][VAL_W-1];
            s3_pp[k] = i_time_step * magnitude(r_s3_vel[k]);
        end
    end

    // ---- stage 4: accumulate, positions, result assembly ----
    t_vec  acc_b_base, acc_b_new;
    t_cvec acc_c_base, acc_c_new;
    t_cvec pos;
    logic  sat_b, sat_c, sat_p;
    logic  wr_b, wr_c;
    t_vec  wdata_b;
    t_cvec wdata_c;
    t_out  res;

    always_comb begin
        logic [TW-1:0]      q3;
        logic [TW-1:0]      q6;
        logic signed [63:0] sum;
        acc_b_base = (r_byp_b_valid && (r_byp_b_idx == r_s4.idx)) ? r_byp_b_data : r_acc_b_rd;
        acc_c_base = (r_byp_c_valid && (r_byp_c_idx == r_s4.idx)) ? r_byp_c_data : r_acc_c_rd;
        sat_b = 1'b0;
        sat_c = 1'b0;
        sat_p = 1'b0;
        for (int j = 0; j < NUM_VAL; j++) begin
            q3 = {r_s4_qh[j], r_s4_pr2[j][K2 +: LO_W]};
            q6 = {1'b0, q3[TW-1:1]};
            sum = add_term(acc_b_base[j], q6, r_s4_na[j]);
            acc_b_new[j] = clamp32(sum);
            sat_b = sat_b | ovf32(sum);
            if (j < NUM_CON) begin
                sum = add_term(acc_c_base[j], q6, r_s4_na[j]);
                acc_c_new[j] = clamp32(sum);
                sat_c = sat_c | ovf32(sum);
            end
        end
        for (int k = 0; k < NUM_CON; k++) begin
            sum = add_term(r_s4_ini[pos_slot(k)], div_n(r_s4_pp[k], r_s4.full_step),
                           r_s4_np[k]);
            pos[k] = clamp32(sum);
            sat_p = sat_p | ovf32(sum);
        end

        wr_b    = r_s4_valid && ((r_s4.kind == K_LOAD_B) || (r_s4.kind == K_EVAL_STEP) ||
                                 (r_s4.kind == K_EVAL_FIN));
        wr_c    = r_s4_valid && ((r_s4.kind == K_LOAD_C) || (r_s4.kind == K_EVAL_C));
        wdata_b = (r_s4.kind == K_LOAD_B) ? r_s4.v : acc_b_new;
        for (int k = 0; k < NUM_CON; k++) begin
            wdata_c[k] = (r_s4.kind == K_LOAD_C) ? r_s4.v[k] : acc_c_new[k];
        end

        res               = '0;
        res.out_index     = r_s4.idx;
        res.stage_now     = r_s4.stage;
        res.sub_step_code = r_s4.sub;
        res.final_flag    = r_s4.fin;
        case (r_s4.kind)
            K_LOAD_B: begin
                res.out_angle            = r_s4.v[0];
                res.out_angular_velocity = r_s4.v[1];
                res.out_position_x       = r_s4.v[2];
                res.out_position_y       = r_s4.v[3];
                res.out_velocity_x       = r_s4.v[4];
                res.out_velocity_y       = r_s4.v[5];
            end
            K_LOAD_C: begin
                res.out_angle            = r_s4.v[0];
                res.out_angular_velocity = r_s4.v[1];
                res.out_position_x       = r_s4.v[2];
            end
            K_EVAL_STEP: begin
                res.out_angle            = pos[0];
                res.out_angular_velocity = r_s4_vel[0];
                res.out_position_x       = pos[1];
                res.out_position_y       = pos[2];
                res.out_velocity_x       = r_s4_vel[1];
                res.out_velocity_y       = r_s4_vel[2];
                res.saturated            = sat_b | r_s4_satv | sat_p;
            end
            K_EVAL_FIN: begin
                res.out_angle            = acc_b_new[0];
                res.out_angular_velocity = acc_b_new[1];
                res.out_position_x       = acc_b_new[2];
                res.out_position_y       = acc_b_new[3];
                res.out_velocity_x       = acc_b_new[4];
                res.out_velocity_y       = acc_b_new[5];
                res.saturated            = sat_b;
            end
            K_EVAL_C: begin
                res.out_angle            = acc_c_new[0];
                res.out_angular_velocity = acc_c_new[1];
                res.out_position_x       = acc_c_new[2];
                res.saturated            = sat_c;
            end
            default: res.saturated = 1'b0;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_s3_valid    <= 1'b0;
            r_s4_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_byp_b_valid <= 1'b0;
            r_byp_c_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid    <= i_cmd_valid;
            r_s2_valid    <= r_s1_valid;
            r_s3_valid    <= r_s2_valid;
            r_s4_valid    <= r_s3_valid;
            r_out_valid   <= r_s4_valid;
            r_byp_b_valid <= wr_b;
            r_byp_c_valid <= wr_c;
        end
    end

    // payload; the whole pipeline advances together
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_cmd;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
            r_s2_ini <= r_s1_ini;
            r_s3_ini <= r_s2_ini;
            r_s4_ini <= r_s3_ini;
            for (int j = 0; j < NUM_VAL; j++) begin
                r_s2_pa[j]  <= s1_pa[j];
                r_s2_na[j]  <= s1_na[j];
                r_s3_th[j]  <= s2_th[j];
                r_s3_tl[j]  <= s2_tl[j];
                r_s3_pr1[j] <= s2_pr1[j];
                r_s3_na[j]  <= r_s2_na[j];
                r_s4_qh[j]  <= s3_qh[j];
                r_s4_pr2[j] <= s3_pr2[j];
                r_s4_na[j]  <= r_s3_na[j];
            end
            for (int k = 0; k < NUM_CON; k++) begin
                r_s2_pv[k] <= s1_pv[k];
                r_s2_nv[k] <= s1_nv[k];
                r_s4_pp[k] <= s3_pp[k];
                r_s4_np[k] <= s3_np[k];
            end
            r_s3_vel  <= s2_vel;
            r_s3_satv <= s2_satv;
            r_s4_vel  <= r_s3_vel;
            r_s4_satv <= r_s3_satv;
            r_out     <= res;
        end
    end

    // initial-state store: loads write at issue, evaluations read at issue
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_pop && (i_cmd.kind == K_LOAD_B)) begin
                r_ini_mem[i_cmd.idx[B_AW-1:0]] <= i_cmd.v;
            end
            r_s1_ini <= r_ini_mem[i_cmd.idx[B_AW-1:0]];
        end
    end

    // accumulators: read entering stage 4, written leaving it
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (wr_b) r_acc_b_mem[r_s4.idx[B_AW-1:0]] <= wdata_b;
            if (wr_c) r_acc_c_mem[r_s4.idx[C_AW-1:0]] <= wdata_c;
            r_acc_b_rd   <= r_acc_b_mem[r_s3.idx[B_AW-1:0]];
            r_acc_c_rd   <= r_acc_c_mem[r_s3.idx[C_AW-1:0]];
            r_byp_b_idx  <= r_s4.idx;
            r_byp_c_idx  <= r_s4.idx;
            r_byp_b_data <= wdata_b;
            r_byp_c_data <= wdata_c;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_s3_to_s4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s3_valid |=> r_s4_valid)
        else $error("stage 3 request lost while advancing");

    a_final_no_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.final_flag |-> r_out.sub_step_code == SUB_NONE)
        else $error("final result carries a sub-step code");

    a_sub_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.sub_step_code != SUB_NONE) |->
        (r_out.stage_now == ST_ONE) || (r_out.stage_now == ST_TWO) ||
        (r_out.stage_now == ST_THREE))
        else $error("sub-step result outside stages one to three");
`endif

endmodule

/* design/rk4_rigid_body_stage_integrator_unit.sv */
// Staged RK4 integrator for planar rigid bodies, top level.
// Requests are queued, then pass the back-end stages and the output register.
// Throughput: one request per cycle; the 4-deep queue and a single pipeline-wide
// advance enable set the rate, and an output stall freezes the whole back end.
// Reset: stage register idle, queue and pipeline empty, time_step 1092;
// body and constraint stores hold nothing until loaded.
module rk4_rigid_body_stage_integrator_unit
    import rk4s_pkg::*;
#(
    parameter int MAX_BODIES      = 64,
    parameter int MAX_CONSTRAINTS = 64,
    parameter int FRAC_BITS       = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in             i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out            o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [DT_W-1:0] i_cfg_data
);

    logic [DT_W-1:0] r_time_step;
    logic            take;
    logic            q_full;
    logic            q_empty;
    logic            pop;
    t_cmd            front_cmd;
    t_cmd            q_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign take        = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= DT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_time_step <= i_cfg_data;
        end
    end

    rk4s_front #(
        .MAX_BODIES      (MAX_BODIES),
        .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_take  (take),
        .o_cmd   (front_cmd)
    );

    rk4s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    rk4s_back #(
        .MAX_BODIES      (MAX_BODIES),
        .MAX_CONSTRAINTS (MAX_CONSTRAINTS),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_time_step (r_time_step),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
